// ===== hdl/bhpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bhpq_pkg;

  localparam int DEPTH   = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int KID_W   = IDX_W + 1;

  localparam int PRIO_W  = 8;
  localparam int ARR_W   = 16;
  localparam int TAG_W   = 10;
  localparam int COUNT_W = 7;
  localparam int ENTRY_W = PRIO_W + ARR_W + TAG_W;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [ARR_W-1:0]  arr;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  typedef struct packed {
    action_t           action;
    logic [PRIO_W-1:0] prio;
    logic [ARR_W-1:0]  arr;
    logic [TAG_W-1:0]  tag;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic [TAG_W-1:0]   tag;
    logic [PRIO_W-1:0]  prio;
    logic [ARR_W-1:0]   arr;
    logic [COUNT_W-1:0] count;
  } result_t;

  typedef struct packed {
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;
    logic [IDX_W-1:0]   rd_a_addr;
    logic [IDX_W-1:0]   rd_b_addr;
  } mem_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_RM_RD,
    S_RM_LOAD,
    S_DN_RD,
    S_DN_CMP,
    S_FIN
  } fsm_state_t;

  // higher priority first, earlier arrival on a tie
  function automatic logic ranks_above(entry_t a, entry_t b);
    logic r;
    if (a.prio != b.prio) begin
      r = (a.prio > b.prio);
    end else begin
      r = (a.arr < b.arr);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bhpq_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bhpq_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [bhpq_pkg::PRIO_W-1:0] priority_req;
  logic [bhpq_pkg::ARR_W-1:0]  arrival_time;
  logic [bhpq_pkg::TAG_W-1:0]  entry_tag;

  modport source (output valid, action, priority_req, arrival_time, entry_tag,
                  input ready);
  modport sink   (input valid, action, priority_req, arrival_time, entry_tag,
                  output ready);
endinterface

interface bhpq_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [bhpq_pkg::TAG_W-1:0]   out_tag;
  logic [bhpq_pkg::PRIO_W-1:0]  out_priority;
  logic [bhpq_pkg::ARR_W-1:0]   out_arrival;
  logic [bhpq_pkg::COUNT_W-1:0] entry_count;

  modport source (output valid, status, out_tag, out_priority, out_arrival, entry_count,
                  input ready);
  modport sink   (input valid, status, out_tag, out_priority, out_arrival, entry_count,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/bhpq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bhpq_ram #(
  parameter int DATA_W = 34,
  parameter int ADDR_W = 6,
  parameter int WORDS  = 64
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic [ADDR_W-1:0] rd_a_addr,
  input  wire logic [ADDR_W-1:0] rd_b_addr,
  output logic      [DATA_W-1:0] rd_a_data,
  output logic      [DATA_W-1:0] rd_b_data
);

  logic [DATA_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

`default_nettype wire

// ===== hdl/bhpq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bhpq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire bhpq_pkg::item_t    in_item,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output bhpq_pkg::result_t       res,
  output bhpq_pkg::mem_req_t      mem_req,
  input  wire bhpq_pkg::entry_t   rd_a_data,
  input  wire bhpq_pkg::entry_t   rd_b_data
);

  bhpq_pkg::fsm_state_t            state_r, state_nxt;
  logic [bhpq_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [bhpq_pkg::IDX_W-1:0]      pos_r, pos_nxt;
  bhpq_pkg::entry_t                hold_r, hold_nxt;
  bhpq_pkg::result_t               res_r, res_nxt;

  logic [bhpq_pkg::IDX_W-1:0]      parent_idx;
  logic [bhpq_pkg::KID_W-1:0]      kid_l, kid_rt, count_ext;
  logic                            left_ok, right_ok, pick_right;
  bhpq_pkg::entry_t                chosen, new_entry;
  logic [bhpq_pkg::IDX_W-1:0]      chosen_idx;

  assign parent_idx = (pos_r - bhpq_pkg::IDX_W'(1)) >> 1;
  assign kid_l      = {pos_r, 1'b1};
  assign kid_rt     = kid_l + bhpq_pkg::KID_W'(1);
  assign count_ext  = bhpq_pkg::KID_W'(count_r);
  assign left_ok    = (kid_l < count_ext);
  assign right_ok   = (kid_rt < count_ext);
  assign pick_right = right_ok && bhpq_pkg::ranks_above(rd_b_data, rd_a_data);
  assign chosen     = pick_right ? rd_b_data : rd_a_data;
  assign chosen_idx = pick_right ? kid_rt[bhpq_pkg::IDX_W-1:0] : kid_l[bhpq_pkg::IDX_W-1:0];

  assign new_entry.prio = in_item.prio;
  assign new_entry.arr  = in_item.arr;
  assign new_entry.tag  = in_item.tag;

  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bhpq_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    hold_r <= hold_nxt;
    res_r  <= res_nxt;
  end

  always_comb begin
    state_nxt         = state_r;
    count_nxt         = count_r;
    pos_nxt           = pos_r;
    hold_nxt          = hold_r;
    res_nxt           = res_r;
    in_ready          = 1'b0;
    res_valid         = 1'b0;
    mem_req.wr_en     = 1'b0;
    mem_req.wr_addr   = pos_r;
    mem_req.wr_data   = hold_r;
    mem_req.rd_a_addr = parent_idx;
    mem_req.rd_b_addr = kid_rt[bhpq_pkg::IDX_W-1:0];

    unique case (state_r)
      bhpq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          res_nxt.status = bhpq_pkg::STAT_DONE;
          res_nxt.tag    = '0;
          res_nxt.prio   = '0;
          res_nxt.arr    = '0;
          res_nxt.count  = bhpq_pkg::COUNT_W'(count_r);
          if (in_item.action == bhpq_pkg::ACT_INSERT) begin
            if (count_r == bhpq_pkg::CNT_W'(bhpq_pkg::DEPTH)) begin
              res_nxt.status = bhpq_pkg::STAT_FULL;
              state_nxt      = bhpq_pkg::S_FIN;
            end else begin
              hold_nxt      = new_entry;
              pos_nxt       = count_r[bhpq_pkg::IDX_W-1:0];
              count_nxt     = count_r + bhpq_pkg::CNT_W'(1);
              res_nxt.count = bhpq_pkg::COUNT_W'(count_r + bhpq_pkg::CNT_W'(1));
              state_nxt     = bhpq_pkg::S_UP_RD;
            end
          end else begin
            if (count_r == '0) begin
              res_nxt.status = bhpq_pkg::STAT_EMPTY;
              state_nxt      = bhpq_pkg::S_FIN;
            end else begin
              count_nxt     = count_r - bhpq_pkg::CNT_W'(1);
              res_nxt.count = bhpq_pkg::COUNT_W'(count_r - bhpq_pkg::CNT_W'(1));
              state_nxt     = bhpq_pkg::S_RM_RD;
            end
          end
        end
      end

      bhpq_pkg::S_UP_RD: begin
        if (pos_r == '0) begin
          mem_req.wr_en = 1'b1;
          state_nxt     = bhpq_pkg::S_FIN;
        end else begin
          state_nxt = bhpq_pkg::S_UP_CMP;
        end
      end

      bhpq_pkg::S_UP_CMP: begin
        mem_req.wr_en = 1'b1;
        if (bhpq_pkg::ranks_above(hold_r, rd_a_data)) begin
          // move the parent down into the hole and climb
          mem_req.wr_data = rd_a_data;
          pos_nxt         = parent_idx;
          state_nxt       = bhpq_pkg::S_UP_RD;
        end else begin
          state_nxt = bhpq_pkg::S_FIN;
        end
      end

      bhpq_pkg::S_RM_RD: begin
        mem_req.rd_a_addr = '0;
        mem_req.rd_b_addr = count_r[bhpq_pkg::IDX_W-1:0];
        state_nxt         = bhpq_pkg::S_RM_LOAD;
      end

      bhpq_pkg::S_RM_LOAD: begin
        res_nxt.tag  = rd_a_data.tag;
        res_nxt.prio = rd_a_data.prio;
        res_nxt.arr  = rd_a_data.arr;
        hold_nxt     = rd_b_data;
        pos_nxt      = '0;
        state_nxt    = (count_r == '0) ? bhpq_pkg::S_FIN : bhpq_pkg::S_DN_RD;
      end

      bhpq_pkg::S_DN_RD: begin
        mem_req.rd_a_addr = kid_l[bhpq_pkg::IDX_W-1:0];
        mem_req.rd_b_addr = kid_rt[bhpq_pkg::IDX_W-1:0];
        if (!left_ok) begin
          mem_req.wr_en = 1'b1;
          state_nxt     = bhpq_pkg::S_FIN;
        end else begin
          state_nxt = bhpq_pkg::S_DN_CMP;
        end
      end

      bhpq_pkg::S_DN_CMP: begin
        mem_req.wr_en = 1'b1;
        if (bhpq_pkg::ranks_above(chosen, hold_r)) begin
          // lift the winning child into the hole and descend
          mem_req.wr_data = chosen;
          pos_nxt         = chosen_idx;
          state_nxt       = bhpq_pkg::S_DN_RD;
        end else begin
          state_nxt = bhpq_pkg::S_FIN;
        end
      end

      bhpq_pkg::S_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = bhpq_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = bhpq_pkg::S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= bhpq_pkg::CNT_W'(bhpq_pkg::DEPTH))
    else $error("fill count above depth");

  a_write_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |-> (bhpq_pkg::CNT_W'(mem_req.wr_addr) < count_r))
    else $error("heap write outside filled entries");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_item.action == bhpq_pkg::ACT_INSERT &&
     count_r != bhpq_pkg::CNT_W'(bhpq_pkg::DEPTH))
    |=> count_r == $past(count_r) + bhpq_pkg::CNT_W'(1))
    else $error("insert did not grow the heap");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status == bhpq_pkg::STAT_EMPTY) |-> (res.count == '0 && count_r == '0))
    else $error("empty status with entries held");
`endif

endmodule

`default_nettype wire

// ===== hdl/binary_max_heap_priority_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Binary max-heap priority queue of bhpq_pkg::DEPTH entries kept in a two-read,
// one-write RAM with registered reads. An insert (action 0) places the entry at
// the end and walks it up; a remove (action 1) returns the root and walks the
// last entry down from the top. Higher priority ranks first; on equal priority
// the smaller arrival stamp wins. Each item gives exactly one result: status
// 0 done, 1 full (insert refused), 2 empty (nothing removed); the data fields
// are nonzero only for a successful remove, and entry_count is the fill after
// the step. One item is worked at a time. Each heap level is a RAM read, then
// a compare and write back. A new item is taken while the previous result
// still sits in the output register.
module binary_max_heap_priority_queue (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bhpq_in_if.sink    in_ch,
  bhpq_out_if.source out_ch
);

  bhpq_pkg::item_t    item;
  bhpq_pkg::result_t  res;
  bhpq_pkg::mem_req_t mem_req;
  bhpq_pkg::entry_t   rd_a_data, rd_b_data;
  logic               res_valid, res_ready;
  logic               out_valid_r, out_valid_nxt;
  bhpq_pkg::result_t  out_r;

  assign item.action = bhpq_pkg::action_t'(in_ch.action);
  assign item.prio   = in_ch.priority_req;
  assign item.arr    = in_ch.arrival_time;
  assign item.tag    = in_ch.entry_tag;

  bhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_req   (mem_req),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  bhpq_ram #(
    .DATA_W (bhpq_pkg::ENTRY_W),
    .ADDR_W (bhpq_pkg::IDX_W),
    .WORDS  (bhpq_pkg::DEPTH)
  ) u_ram (
    .clk       (clk),
    .wr_en     (mem_req.wr_en),
    .wr_addr   (mem_req.wr_addr),
    .wr_data   (mem_req.wr_data),
    .rd_a_addr (mem_req.rd_a_addr),
    .rd_b_addr (mem_req.rd_b_addr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  // output register: load when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_r.status;
  assign out_ch.out_tag      = out_r.tag;
  assign out_ch.out_priority = out_r.prio;
  assign out_ch.out_arrival  = out_r.arr;
  assign out_ch.entry_count  = out_r.count;

endmodule

`default_nettype wire
